// ----- sv/dxt_mip_chain_vertical_flip_defines.svh -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: assertion macros
// Concurrent assertion helpers shared by the modules of the block. They
// expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DXT_MIP_CHAIN_VERTICAL_FLIP_DEFINES_SVH
`define DXT_MIP_CHAIN_VERTICAL_FLIP_DEFINES_SVH
`ifndef SYNTH
// Checked on every rising edge of clk, ignored while arst_n is low.
`define DXTF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define DXTF_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DXTF_ASSERT(name, prop, msg)
`define DXTF_ASSERT_RST(name, prop, msg)
`endif
`endif

// ----- sv/dxtf_pkg.sv -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: package
// Shared widths, codes, item types and small helper functions.
// ----------------------------------------------------------------------------
package dxtf_pkg;

	// Limits of the mip chain.
	localparam int MAX_DIM    = 16384;
	localparam int MAX_LEVELS = 15;

	// Field widths.
	localparam int DIM_W      = 15;
	localparam int BLK_W      = 13;
	localparam int IDX_W      = 12;
	localparam int LVL_W      = 4;
	localparam int OFF_W      = 29;
	localparam int PROD_W     = IDX_W + BLK_W;
	localparam int DATA_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Block sizes in bytes.
	localparam logic [OFF_W-1:0] BYTES_NARROW = OFF_W'(8);
	localparam logic [OFF_W-1:0] BYTES_WIDE   = OFF_W'(16);

	typedef enum logic [1:0] {
		FMT_DXT1 = 2'd0,
		FMT_DXT3 = 2'd1,
		FMT_DXT5 = 2'd2
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT = 3'd0,
		REG_WIDTH  = 3'd1,
		REG_HEIGHT = 3'd2,
		REG_LEVELS = 3'd3
	} reg_idx_t;

	// Register reset values.
	localparam fmt_t             RST_FORMAT = FMT_DXT1;
	localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(4);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(4);
	localparam logic [LVL_W-1:0] RST_LEVELS = LVL_W'(1);

	typedef struct packed {
		logic [DATA_W-1:0] block_low;
		logic [DATA_W-1:0] block_high;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] flipped_low;
		logic [DATA_W-1:0] flipped_high;
		logic [OFF_W-1:0]  dest_offset;
		logic              last_block;
	} out_item_t;

	// Position of the current block in the chain, handed to the datapath.
	typedef struct packed {
		fmt_t              fmt;
		logic [IDX_W-1:0]  row_rev;
		logic [BLK_W-1:0]  bx;
		logic [IDX_W-1:0]  col;
		logic [OFF_W-1:0]  base;
		logic              last;
	} pos_t;

	// Zero becomes 1, anything above the limit is held at the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) r = DIM_W'(1);
		else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
		return r;
	endfunction

	// Next level size: half, never below 1.
	function automatic logic [DIM_W-1:0] halve_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] h;
		h = d >> 1;
		return (h == '0) ? DIM_W'(1) : h;
	endfunction

	// Number of 4x4 blocks covering a pixel size.
	function automatic logic [BLK_W-1:0] blocks_of(input logic [DIM_W-1:0] d);
		logic [DIM_W:0] s;
		s = {1'b0, d} + (DIM_W+1)'(3);
		return s[DIM_W-1:2];
	endfunction

endpackage

// ----- sv/dxtf_flip.sv -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: block rewiring
// Reorders the rows of one compressed block according to its format.
// ----------------------------------------------------------------------------
module dxtf_flip (
	input  dxtf_pkg::fmt_t                 fmt,
	input  dxtf_pkg::in_item_t             blk,
	output logic [dxtf_pkg::DATA_W-1:0]    flo,
	output logic [dxtf_pkg::DATA_W-1:0]    fhi
);
	import dxtf_pkg::*;

	logic [DATA_W-1:0] lo_keep_rev;
	logic [DATA_W-1:0] hi_keep_rev;
	logic [DATA_W-1:0] lo_rev16;
	logic [DATA_W-1:0] lo_dxt5;
	logic [23:0]       grp_a;
	logic [23:0]       grp_b;

	// Colour part: endpoints kept, the four index rows reversed.
	always_comb begin
		lo_keep_rev = blk.block_low;
		hi_keep_rev = blk.block_high;
		for (int i = 0; i < 4; i++) begin
			lo_keep_rev[8*(4+i) +: 8] = blk.block_low[8*(7-i) +: 8];
			hi_keep_rev[8*(4+i) +: 8] = blk.block_high[8*(7-i) +: 8];
		end
	end

	// Explicit alpha: the four 16-bit rows reversed.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lo_rev16[16*k +: 16] = blk.block_low[16*(3-k) +: 16];
		end
	end

	// Interpolated alpha: endpoints kept, each 24-bit index group has its
	// halves swapped and the two groups change places.
	assign grp_a   = blk.block_low[39:16];
	assign grp_b   = blk.block_low[63:40];
	assign lo_dxt5 = {grp_a[11:0], grp_a[23:12], grp_b[11:0], grp_b[23:12],
		blk.block_low[15:0]};

	// Select by format; the unused code behaves as DXT5.
	always_comb begin
		case (fmt)
			FMT_DXT1: begin
				flo = lo_keep_rev;
				fhi = '0;
			end
			FMT_DXT3: begin
				flo = lo_rev16;
				fhi = hi_keep_rev;
			end
			default: begin
				flo = lo_dxt5;
				fhi = hi_keep_rev;
			end
		endcase
	end

endmodule

// ----- sv/dxtf_walk.sv -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: chain walker
// Holds the configuration registers and the column, row and level counters,
// and gives the position of the next block in the flipped chain.
// ----------------------------------------------------------------------------
`include "dxt_mip_chain_vertical_flip_defines.svh"

module dxtf_walk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [dxtf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dxtf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              adv,
	output dxtf_pkg::pos_t                    pos
);
	import dxtf_pkg::*;

	// Configuration registers.
	fmt_t             fmt_q;
	logic [DIM_W-1:0] base_w_q;
	logic [DIM_W-1:0] base_h_q;
	logic [LVL_W-1:0] lvl_cnt_q;

	// Chain position.
	logic [LVL_W-1:0] lvl_idx_q;
	logic [DIM_W-1:0] lvl_w_q;
	logic [DIM_W-1:0] lvl_h_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic [OFF_W-1:0] base_q;
	logic [OFF_W-1:0] acc_q;

	fmt_t             fmt_n;
	logic [DIM_W-1:0] base_w_n;
	logic [DIM_W-1:0] base_h_n;
	logic [LVL_W-1:0] lvl_cnt_n;
	logic             cfg_hit;
	reg_idx_t         widx;

	logic [BLK_W-1:0] bx;
	logic [BLK_W-1:0] by;
	logic [BLK_W-1:0] col_inc;
	logic [BLK_W-1:0] row_inc;
	logic [BLK_W-1:0] row_rev_full;
	logic [LVL_W:0]   lvl_inc;
	logic [LVL_W-1:0] lvl_used;
	logic             last_col;
	logic             last_row;
	logic             last_lvl;
	logic [OFF_W-1:0] step;
	logic [OFF_W-1:0] acc_nxt;

	// Decode a register write; every known index restarts the chain.
	assign widx = reg_idx_t'(cfg_index);

	always_comb begin
		fmt_n     = fmt_q;
		base_w_n  = base_w_q;
		base_h_n  = base_h_q;
		lvl_cnt_n = lvl_cnt_q;
		cfg_hit   = 1'b0;
		if (cfg_valid) begin
			case (widx)
				REG_FORMAT: begin
					fmt_n   = fmt_t'(cfg_data[1:0]);
					cfg_hit = 1'b1;
				end
				REG_WIDTH: begin
					base_w_n = cfg_data;
					cfg_hit  = 1'b1;
				end
				REG_HEIGHT: begin
					base_h_n = cfg_data;
					cfg_hit  = 1'b1;
				end
				REG_LEVELS: begin
					lvl_cnt_n = cfg_data[LVL_W-1:0];
					cfg_hit   = 1'b1;
				end
				default: begin
					cfg_hit = 1'b0;
				end
			endcase
		end
	end

	// Level geometry and end-of-row, end-of-level detection.
	assign bx       = blocks_of(lvl_w_q);
	assign by       = blocks_of(lvl_h_q);
	assign col_inc  = {1'b0, col_q} + BLK_W'(1);
	assign row_inc  = {1'b0, row_q} + BLK_W'(1);
	assign last_col = (col_inc >= bx);
	assign last_row = (row_inc >= by);

	always_comb begin
		lvl_used = lvl_cnt_q;
		if (lvl_cnt_q == '0) lvl_used = LVL_W'(1);
		else if (lvl_cnt_q > LVL_W'(MAX_LEVELS)) lvl_used = LVL_W'(MAX_LEVELS);
	end

	assign lvl_inc  = {1'b0, lvl_idx_q} + (LVL_W+1)'(1);
	assign last_lvl = (lvl_inc >= {1'b0, lvl_used});

	// The running byte count of the chain gives the start of the next level.
	assign step    = (fmt_q == FMT_DXT1) ? BYTES_NARROW : BYTES_WIDE;
	assign acc_nxt = acc_q + step;

	assign row_rev_full = by - BLK_W'(1) - {1'b0, row_q};

	always_comb begin
		pos.fmt     = fmt_q;
		pos.row_rev = row_rev_full[IDX_W-1:0];
		pos.bx      = bx;
		pos.col     = col_q;
		pos.base    = base_q;
		pos.last    = last_col && last_row && last_lvl;
	end

	// Register writes restart the chain from the new contents; otherwise
	// each accepted item steps the counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= RST_FORMAT;
			base_w_q  <= RST_WIDTH;
			base_h_q  <= RST_HEIGHT;
			lvl_cnt_q <= RST_LEVELS;
			lvl_idx_q <= '0;
			lvl_w_q   <= clamp_dim(RST_WIDTH);
			lvl_h_q   <= clamp_dim(RST_HEIGHT);
			col_q     <= '0;
			row_q     <= '0;
			base_q    <= '0;
			acc_q     <= '0;
		end else if (cfg_hit) begin
			fmt_q     <= fmt_n;
			base_w_q  <= base_w_n;
			base_h_q  <= base_h_n;
			lvl_cnt_q <= lvl_cnt_n;
			lvl_idx_q <= '0;
			lvl_w_q   <= clamp_dim(base_w_n);
			lvl_h_q   <= clamp_dim(base_h_n);
			col_q     <= '0;
			row_q     <= '0;
			base_q    <= '0;
			acc_q     <= '0;
		end else if (adv) begin
			// The running count starts again with the chain after its last block.
			acc_q <= pos.last ? '0 : acc_nxt;
			if (!last_col) begin
				col_q <= col_inc[IDX_W-1:0];
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_inc[IDX_W-1:0];
				end else if (last_lvl) begin
					lvl_idx_q <= '0;
					lvl_w_q   <= clamp_dim(base_w_q);
					lvl_h_q   <= clamp_dim(base_h_q);
					row_q     <= '0;
					base_q    <= '0;
				end else begin
					row_q     <= '0;
					base_q    <= acc_nxt;
					lvl_w_q   <= halve_dim(lvl_w_q);
					lvl_h_q   <= halve_dim(lvl_h_q);
					lvl_idx_q <= lvl_inc[LVL_W-1:0];
				end
			end
		end
	end

	`DXTF_ASSERT(a_col_in_row, ({1'b0, col_q} < bx), "block column beyond row width")
	`DXTF_ASSERT(a_row_in_level, ({1'b0, row_q} < by), "block row beyond level height")
	`DXTF_ASSERT(a_wrap_restarts, (adv && pos.last && !cfg_hit) |=> (col_q == '0 && row_q == '0 && lvl_idx_q == '0 && acc_q == '0), "chain did not restart after its last block")

endmodule

// ----- sv/dxtf_pipe.sv -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: offset pipeline
// Three-stage elastic pipeline: input register, row offset product and
// result register with the destination byte offset.
// ----------------------------------------------------------------------------
`include "dxt_mip_chain_vertical_flip_defines.svh"

module dxtf_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  logic [dxtf_pkg::DATA_W-1:0]    flo,
	input  logic [dxtf_pkg::DATA_W-1:0]    fhi,
	input  dxtf_pkg::pos_t                 pos,
	output logic                           adv,
	output logic                           res_valid,
	input  logic                           res_stall,
	output dxtf_pkg::out_item_t            res_item
);
	import dxtf_pkg::*;

	logic              vld_s1;
	logic [DATA_W-1:0] lo_s1;
	logic [DATA_W-1:0] hi_s1;
	pos_t              pos_s1;

	logic              vld_s2;
	logic [DATA_W-1:0] lo_s2;
	logic [DATA_W-1:0] hi_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [IDX_W-1:0]  col_s2;
	logic [OFF_W-1:0]  base_s2;
	logic              wide_s2;
	logic              last_s2;

	logic              vld_s3;
	out_item_t         res_s3;

	logic              load_s1;
	logic              load_s2;
	logic              load_s3;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] blk_idx;
	logic [OFF_W-1:0]  blk_bytes;

	// A stage loads when it is empty or its contents move on.
	assign load_s3   = !vld_s3 || !res_stall;
	assign load_s2   = !vld_s2 || load_s3;
	assign load_s1   = !vld_s1 || load_s2;
	assign src_stall = !load_s1;
	assign adv       = src_valid && load_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (load_s1) vld_s1 <= src_valid;
			if (load_s2) vld_s2 <= vld_s1;
			if (load_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: flipped block and its position.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			lo_s1  <= flo;
			hi_s1  <= fhi;
			pos_s1 <= pos;
		end
	end

	// Stage 2: blocks preceding the destination row within the level.
	assign prod = PROD_W'(pos_s1.row_rev) * PROD_W'(pos_s1.bx);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			prod_s2 <= prod;
			col_s2  <= pos_s1.col;
			base_s2 <= pos_s1.base;
			wide_s2 <= (pos_s1.fmt != FMT_DXT1);
			last_s2 <= pos_s1.last;
		end
	end

	// Stage 3: byte offset, wrapping at the offset width.
	assign blk_idx   = prod_s2 + PROD_W'(col_s2);
	assign blk_bytes = wide_s2 ? OFF_W'({blk_idx, 4'b0}) : OFF_W'({blk_idx, 3'b0});

	always_ff @(posedge clk) begin
		if (load_s3) begin
			res_s3.flipped_low  <= lo_s2;
			res_s3.flipped_high <= hi_s2;
			res_s3.dest_offset  <= base_s2 + blk_bytes;
			res_s3.last_block   <= last_s2;
		end
	end

	assign res_valid = vld_s3;
	assign res_item  = res_s3;

	`DXTF_ASSERT(a_stall_only_full, src_stall |-> (vld_s1 && vld_s2 && vld_s3), "input stalled with a free stage")
	`DXTF_ASSERT(a_s2_holds, (vld_s2 && vld_s3 && res_stall) |=> (vld_s2 && $stable(prod_s2)), "stage 2 lost its item under stall")
	`DXTF_ASSERT_RST(a_reset_empty, !arst_n |-> !res_valid, "result valid during reset")

endmodule

// ----- sv/dxt_mip_chain_vertical_flip.sv -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: top level
// Flips DXT1, DXT3 and DXT5 blocks of a whole mip chain and places them.
// ----------------------------------------------------------------------------
// Usage. Configuration is written through cfg_valid/cfg_ready with a
// register index and data (format, base width, base height, level count);
// cfg_ready is always high and a write to any known index restarts the
// chain. Write only while the block holds no item.
// Source items (src_item) are compressed blocks in source order and are
// taken at an edge where src_valid is high and src_stall low. Each gives
// one result item on res_item: the flipped block, its byte offset in the
// flipped chain and a flag on the final block of the last level, after
// which the counters return to the start of the chain.
// An accepted item passes the input, product and result registers before it
// can be taken; one item is accepted per cycle while src_stall is low, in the
// three-stage offset pipeline. While res_stall is high the result holds and
// the pipeline fills; src_stall rises once all three stages are occupied.
// Reset empties the pipeline and loads DXT1, 4 by 4 pixels and one level.
// ----------------------------------------------------------------------------
module dxt_mip_chain_vertical_flip (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dxtf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dxtf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  dxtf_pkg::in_item_t                src_item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output dxtf_pkg::out_item_t               res_item
);
	import dxtf_pkg::*;

	pos_t              pos;
	logic              adv;
	logic [DATA_W-1:0] flo;
	logic [DATA_W-1:0] fhi;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	// Chain position and configuration.
	dxtf_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.pos       (pos)
	);

	// Row reordering of the incoming block.
	dxtf_flip u_flip (
		.fmt (pos.fmt),
		.blk (src_item),
		.flo (flo),
		.fhi (fhi)
	);

	// Offset computation and output register.
	dxtf_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.flo       (flo),
		.fhi       (fhi),
		.pos       (pos),
		.adv       (adv),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// DXT mip chain vertical flip: testbench
// Sends compressed DXT1, DXT3 and DXT5 blocks through the flip block and
// checks every flipped block, its destination offset and the end-of-chain
// flag against an in-bench model of the flip and of the chain counters.
// Directed items cover the formats and the size extremes. Random chains
// then run under several patterns of sender gaps and receiver stalls, and a
// long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
	import dxtf_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 310;
	localparam int CHAIN_CAP   = 250;
	localparam int REPORT_MAX  = 10;
	localparam int LATENCY_PAD = 8;

	// Register index with no register behind it, and the format code left spare.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam logic [1:0]           FMT_SPARE  = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  src_valid = 1'b0;
	logic                  src_stall;
	in_item_t              src_item  = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	out_item_t             res_item;

	// Register copies kept by the bench.
	logic [1:0]       fmt_code;
	logic [DIM_W-1:0] top_width;
	logic [DIM_W-1:0] top_height;
	logic [LVL_W-1:0] chain_levels;

	// Position in the chain as the bench tracks it.
	logic [LVL_W-1:0] lvl_idx;
	logic [DIM_W-1:0] lvl_w;
	logic [DIM_W-1:0] lvl_h;
	logic [IDX_W-1:0] blk_col;
	logic [IDX_W-1:0] blk_row;
	logic [OFF_W-1:0] lvl_base;

	out_item_t expected_q[$];
	int        fails         = 0;
	int        results_seen  = 0;
	int        quiet_cycles  = 0;
	int        src_idle_pct  = 0;
	int        res_stall_pct = 0;
	bit        hold_request  = 1'b0;

	dxt_mip_chain_vertical_flip dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Zero counts as one pixel, anything past the limit is held at the limit.
	function automatic int fit_dim(input int d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	function automatic int fit_levels(input int n);
		if (n == 0)
			return 1;
		if (n > MAX_LEVELS)
			return MAX_LEVELS;
		return n;
	endfunction

	// Back to the first block of the top level.
	function automatic void rewind_chain();
		lvl_idx  = '0;
		lvl_w    = DIM_W'(fit_dim(top_width));
		lvl_h    = DIM_W'(fit_dim(top_height));
		blk_col  = '0;
		blk_row  = '0;
		lvl_base = '0;
	endfunction

	// Bytes 0 to 3 stay, bytes 4 to 7 are the colour index rows, reversed.
	function automatic logic [DATA_W-1:0] rev_upper_bytes(input logic [DATA_W-1:0] v);
		return {v[39:32], v[47:40], v[55:48], v[63:56], v[31:0]};
	endfunction

	// Flipped block and destination of one source block; moves the chain on.
	function automatic out_item_t flip_and_place(input in_item_t b);
		out_item_t       r;
		longint unsigned bsize;
		longint unsigned bx;
		longint unsigned by;
		longint unsigned row_bytes;
		longint unsigned off;
		logic [23:0]     grp_a;
		logic [23:0]     grp_b;
		bit              last_col;
		bit              last_row;
		bit              last_lvl;

		bsize     = (fmt_code == FMT_DXT1) ? 8 : 16;
		bx        = (lvl_w + 3) / 4;
		by        = (lvl_h + 3) / 4;
		row_bytes = bx * bsize;

		case (fmt_code)
			FMT_DXT1: begin
				r.flipped_low  = rev_upper_bytes(b.block_low);
				r.flipped_high = '0;
			end
			FMT_DXT3: begin
				// Four 16-bit alpha rows in reverse order.
				r.flipped_low  = {b.block_low[15:0], b.block_low[31:16],
					b.block_low[47:32], b.block_low[63:48]};
				r.flipped_high = rev_upper_bytes(b.block_high);
			end
			default: begin
				// Endpoints stay; the two alpha index groups trade places,
				// each with its 12-bit row pairs swapped.
				grp_a          = b.block_low[39:16];
				grp_b          = b.block_low[63:40];
				r.flipped_low  = {grp_a[11:0], grp_a[23:12], grp_b[11:0], grp_b[23:12],
					b.block_low[15:0]};
				r.flipped_high = rev_upper_bytes(b.block_high);
			end
		endcase

		// Block rows of a level land in reverse order.
		off           = lvl_base + (by - 1 - blk_row) * row_bytes + blk_col * bsize;
		r.dest_offset = OFF_W'(off);

		last_col     = (blk_col + 1 >= bx);
		last_row     = (blk_row + 1 >= by);
		last_lvl     = (lvl_idx + 1 >= fit_levels(chain_levels));
		r.last_block = last_col && last_row && last_lvl;

		if (!last_col) begin
			blk_col = blk_col + 1'b1;
		end else begin
			blk_col = '0;
			if (!last_row) begin
				blk_row = blk_row + 1'b1;
			end else if (last_lvl) begin
				rewind_chain();
			end else begin
				blk_row  = '0;
				lvl_base = OFF_W'(lvl_base + by * row_bytes);
				lvl_w    = ((lvl_w >> 1) == 0) ? DIM_W'(1) : (lvl_w >> 1);
				lvl_h    = ((lvl_h >> 1) == 0) ? DIM_W'(1) : (lvl_h >> 1);
				lvl_idx  = lvl_idx + 1'b1;
			end
		end
		return r;
	endfunction

	function automatic in_item_t random_block();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Mostly small sizes, now and then anything up to and past the limit.
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			0:       return DIM_W'($urandom_range(0, 32767));
			1:       return DIM_W'($urandom_range(1, MAX_DIM));
			default: return DIM_W'($urandom_range(1, 24));
		endcase
	endfunction

	// Checks each result against the oldest expectation, then records the
	// expectation of any item taken at the same edge.
	always @(posedge clk) begin : result_check
		out_item_t want;
		bit        bad;

		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("error: result %0d arrived with no item outstanding",
							results_seen);
				end else begin
					want = expected_q.pop_front();
					bad  = 1'b0;
					if (res_item.flipped_low !== want.flipped_low)
						bad = 1'b1;
					if (res_item.flipped_high !== want.flipped_high)
						bad = 1'b1;
					if (res_item.dest_offset !== want.dest_offset)
						bad = 1'b1;
					if (res_item.last_block !== want.last_block)
						bad = 1'b1;
					if (bad) begin
						fails++;
						if (fails <= REPORT_MAX) begin
							$display("error: result %0d expected lo %h hi %h off %h last %b",
								results_seen, want.flipped_low, want.flipped_high,
								want.dest_offset, want.last_block);
							$display("error: result %0d got      lo %h hi %h off %h last %b",
								results_seen, res_item.flipped_low, res_item.flipped_high,
								res_item.dest_offset, res_item.last_block);
						end
					end
				end
			end
			if (src_valid && !src_stall)
				expected_q.push_back(flip_and_place(src_item));
		end
	end

	// Receiver: random stalls, or one long hold-off when asked for.
	always begin : result_sink
		@(negedge clk);
		if (hold_request) begin
			res_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_request = 1'b0;
		end
		res_stall <= ($urandom_range(99) < res_stall_pct);
	end

	// Ends the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("dxt_mip_chain_vertical_flip: mismatch");
			$finish;
		end
	end

	// Offers one item after a random gap and waits until it is taken.
	// Called and returning just after a falling edge.
	task automatic send_block(input in_item_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= b;
		do @(posedge clk); while (src_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits until every item has come out.
	task automatic settle();
		src_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		bit known;

		known = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FORMAT: fmt_code     = val[1:0];
			REG_WIDTH:  top_width    = val;
			REG_HEIGHT: top_height   = val;
			REG_LEVELS: chain_levels = val[LVL_W-1:0];
			default:    known        = 1'b0;
		endcase
		// Any write to a real register starts the chain again.
		if (known)
			rewind_chain();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Unused upper data bits of the narrow registers carry noise.
	task automatic load_chain_setup(input logic [1:0] f, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h, input logic [LVL_W-1:0] lv);
		settle();
		write_reg(REG_FORMAT, {(CFG_DATA_W-2)'($urandom), f});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LEVELS, {(CFG_DATA_W-LVL_W)'($urandom), lv});
	endtask

	// Each format, and the spare code, on a one-block chain with fixed patterns.
	task automatic test_formats();
		logic [1:0] fmts [4] = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_SPARE};
		in_item_t   pats [3] = '{128'h0, {128{1'b1}},
			{64'h0123_4567_89ab_cdef, 64'h1f2e_3d4c_5b6a_7988}};

		foreach (fmts[i]) begin
			load_chain_setup(fmts[i], 15'd4, 15'd4, 4'd1);
			foreach (pats[k])
				send_block(pats[k]);
		end
	endtask

	// Zero sizes and level count, sizes past the limit, and a tall thin chain.
	task automatic test_dimension_extremes();
		load_chain_setup(FMT_DXT1, 15'd0, 15'd0, 4'd0);
		repeat (2) send_block(random_block());
		load_chain_setup(FMT_DXT5, 15'd32767, 15'd32767, 4'd15);
		repeat (3) send_block(random_block());
		load_chain_setup(FMT_DXT3, 15'd1, DIM_W'(MAX_DIM), 4'd15);
		repeat (2) send_block(random_block());
	endtask

	// A write to an index with no register must leave the chain where it is;
	// the last items wrap past the end of the chain.
	task automatic test_unused_register();
		load_chain_setup(FMT_DXT3, 15'd8, 15'd8, 4'd2);
		repeat (2) send_block(random_block());
		settle();
		write_reg(REG_UNUSED, '1);
		repeat (4) send_block(random_block());
	endtask

	// Random settings, each followed by one to two chain lengths of items, capped at CHAIN_CAP, often wrapping.
	task automatic test_random_chains(input int idle_pct, input int stall_pct);
		int               sent;
		int               blocks;
		int               n;
		int               w_left;
		int               h_left;
		logic [1:0]       f;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [LVL_W-1:0] lv;

		settle();
		src_idle_pct  = idle_pct;
		res_stall_pct = stall_pct;
		sent          = 0;
		while (sent < PHASE_ITEMS) begin
			f  = 2'($urandom_range(3));
			w  = pick_dim();
			h  = pick_dim();
			lv = LVL_W'($urandom_range(15));
			load_chain_setup(f, w, h, lv);

			blocks = 0;
			w_left = fit_dim(w);
			h_left = fit_dim(h);
			for (int l = 0; l < fit_levels(lv); l++) begin
				blocks += ((w_left + 3) / 4) * ((h_left + 3) / 4);
				w_left = (w_left / 2 == 0) ? 1 : w_left / 2;
				h_left = (h_left / 2 == 0) ? 1 : h_left / 2;
			end
			n = blocks + $urandom_range(0, blocks);
			if (n > CHAIN_CAP)
				n = CHAIN_CAP;
			repeat (n) send_block(random_block());
			sent += n;
		end
	endtask

	// Receiver holds off for a long stretch while items keep coming.
	task automatic test_backpressure();
		settle();
		src_idle_pct  = 0;
		res_stall_pct = 0;
		load_chain_setup(FMT_DXT5, 15'd20, 15'd12, 4'd3);
		hold_request = 1'b1;
		repeat (40) send_block(random_block());
	endtask

	initial begin : run
		// Reset goes low at time zero as a real edge, so the registers clear
		// before the first rising clock edge.
		arst_n <= 1'b0;

		fmt_code     = RST_FORMAT;
		top_width    = RST_WIDTH;
		top_height   = RST_HEIGHT;
		chain_levels = RST_LEVELS;
		rewind_chain();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_formats();
		test_dimension_extremes();
		test_unused_register();
		test_random_chains(0, 0);
		test_random_chains(68, 0);
		test_random_chains(0, 68);
		test_random_chains(37, 37);
		test_backpressure();
		settle();

		if (fails == 0)
			$display("dxt_mip_chain_vertical_flip: match");
		else
			$display("dxt_mip_chain_vertical_flip: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dxtf_pkg.sv
sv/dxtf_flip.sv
sv/dxtf_walk.sv
sv/dxtf_pipe.sv
sv/dxt_mip_chain_vertical_flip.sv
tb/tb.sv
